FILE: sv/dsdc_pkg.sv
package dsdc_pkg;

  // Defaults for the top-level parameters.
  localparam int DSDC_CORDIC_STEPS = 16;
  localparam int DSDC_SUM_WIDTH    = 32;

  // Fixed field widths.
  localparam int KIND_W   = 2;
  localparam int ID_W     = 2;
  localparam int DELTA_W  = 16;
  localparam int CFG_W    = 16;
  localparam int OFF_W    = 17;
  localparam int STORE_W  = 18;
  localparam int THETA_W  = 17;
  localparam int MAG_W    = 32;
  localparam int TRAVEL_W = 33;

  // CORDIC arithmetic.
  localparam int GUARD      = 8;
  localparam int TAB_IW     = 5;
  localparam int ANG_W      = 34;
  localparam int THETA_LIM  = 32768;
  localparam int THETA_RND  = 32768;
  localparam int THETA_SH   = 16;
  localparam int GAIN_W     = 20;
  localparam int GAIN_FRAC  = 20;
  localparam int MAG_LIM_W  = 34 + GUARD;
  localparam int MUL_SPLIT  = 21;
  localparam int MUL_HI_W   = MAG_LIM_W - MUL_SPLIT;
  localparam int ANG_REF    = 16384;

  localparam logic [GAIN_W-1:0]       GAIN_Q20   = 20'd636751;
  localparam logic [MAG_W-1:0]        TRAVEL_MAX = 32'd3037000500;
  localparam logic signed [ANG_W-1:0] ANG_PI     = 34'sd2147483648;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STOP   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CAL    = 2'd3;

  // Sensor selectors.
  localparam logic [ID_W-1:0] SENSOR_ONE = 2'd0;
  localparam logic [ID_W-1:0] SENSOR_TWO = 2'd1;

  // Result of one vectoring run.
  typedef struct packed {
    logic                      done;
    logic signed [THETA_W-1:0] theta;
    logic [MAG_W-1:0]          mag;
  } dsdc_cres_t;

  // Arctangent of 2^-i in units of pi/2^31.
  function automatic logic [ANG_W-1:0] atan_entry(input logic [TAB_IW-1:0] idx);
    logic [ANG_W-1:0] v;
    case (idx)
      5'd0:    v = 34'd536870912;
      5'd1:    v = 34'd316933406;
      5'd2:    v = 34'd167458907;
      5'd3:    v = 34'd85004756;
      5'd4:    v = 34'd42667331;
      5'd5:    v = 34'd21354465;
      5'd6:    v = 34'd10679838;
      5'd7:    v = 34'd5341269;
      5'd8:    v = 34'd2670163;
      5'd9:    v = 34'd1335087;
      5'd10:   v = 34'd667544;
      5'd11:   v = 34'd333772;
      5'd12:   v = 34'd166886;
      5'd13:   v = 34'd83443;
      5'd14:   v = 34'd41722;
      5'd15:   v = 34'd20861;
      5'd16:   v = 34'd10430;
      5'd17:   v = 34'd5215;
      5'd18:   v = 34'd2608;
      5'd19:   v = 34'd1304;
      5'd20:   v = 34'd652;
      5'd21:   v = 34'd326;
      5'd22:   v = 34'd163;
      5'd23:   v = 34'd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/dsdc_if.sv
interface dsdc_in_if;
  import dsdc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic [ID_W-1:0]           sensor_id;
  logic signed [DELTA_W-1:0] delta_x;
  logic signed [DELTA_W-1:0] delta_y;

  modport source (output valid, kind, sensor_id, delta_x, delta_y, input ready);
  modport sink   (input valid, kind, sensor_id, delta_x, delta_y, output ready);
endinterface

interface dsdc_out_if;
  import dsdc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       calibrating_flag;
  logic signed [OFF_W-1:0]    offset_one;
  logic signed [OFF_W-1:0]    offset_two;
  logic signed [TRAVEL_W-1:0] travel_one;
  logic signed [TRAVEL_W-1:0] travel_two;

  modport source (output valid, calibrating_flag, offset_one, offset_two, travel_one,
                  travel_two, input ready);
  modport sink   (input valid, calibrating_flag, offset_one, offset_two, travel_one,
                  travel_two, output ready);
endinterface

FILE: sv/dsdc_cordic.sv
module dsdc_cordic #(
  parameter int CORDIC_STEPS = dsdc_pkg::DSDC_CORDIC_STEPS,
  parameter int SUM_WIDTH    = dsdc_pkg::DSDC_SUM_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [SUM_WIDTH-1:0] x_in,
  input  logic signed [SUM_WIDTH-1:0] y_in,
  output dsdc_pkg::dsdc_cres_t        res
);
  import dsdc_pkg::*;

  localparam int XW   = SUM_WIDTH + GUARD + 2;
  localparam int IW   = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int EW   = (XW > MAG_LIM_W) ? XW : MAG_LIM_W;
  localparam int PW   = MAG_LIM_W + GAIN_W + 1;
  localparam int QW   = PW - GAIN_FRAC - GUARD;
  localparam int PRODW = MUL_SPLIT + GAIN_W;
  localparam logic [IW-1:0] LAST = IW'(CORDIC_STEPS - 1);
  localparam logic signed [ANG_W-1:0] T_HI = ANG_W'(THETA_LIM);
  localparam logic signed [ANG_W-1:0] T_LO = -T_HI;
  localparam logic signed [ANG_W-1:0] Z_RND = ANG_W'(THETA_RND);
  localparam logic [PW-1:0] P_RND = PW'(1) << (GAIN_FRAC + GUARD - 1);

  localparam logic [2:0] C_IDLE   = 3'd0;
  localparam logic [2:0] C_ITER   = 3'd1;
  localparam logic [2:0] C_PREP   = 3'd2;
  localparam logic [2:0] C_MUL_LO = 3'd3;
  localparam logic [2:0] C_MUL_HI = 3'd4;
  localparam logic [2:0] C_FIN    = 3'd5;

  logic [2:0]                state_r, state_nxt;
  logic [IW-1:0]             step_r, step_nxt;
  logic signed [XW-1:0]      x_r, x_nxt, y_r, y_nxt;
  logic signed [ANG_W-1:0]   z_r, z_nxt;
  logic signed [THETA_W-1:0] theta_r, theta_nxt;
  logic [MAG_W-1:0]          mag_r, mag_nxt;
  logic                      done_r, done_nxt;
  logic [MAG_LIM_W-1:0]      um_r, um_nxt;
  logic                      big_r, big_nxt;
  logic [PW-1:0]             acc_r, acc_nxt;

  logic signed [XW-1:0]      x_sc, y_sc, dx, dy, x_pos;
  logic signed [ANG_W-1:0]   tab, zr, t;
  logic [EW-1:0]             x_ext;
  logic [MUL_SPLIT-1:0]      mul_a;
  logic [PRODW-1:0]          prod;
  logic [QW-1:0]             q;

  // Single shared multiplier for both halves of the gain correction.
  assign mul_a = (state_r == C_MUL_HI) ? MUL_SPLIT'(um_r[MAG_LIM_W-1:MUL_SPLIT])
                                       : um_r[MUL_SPLIT-1:0];
  assign prod  = PRODW'(mul_a) * PRODW'(GAIN_Q20);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    theta_nxt = theta_r;
    mag_nxt   = mag_r;
    done_nxt  = 1'b0;
    um_nxt    = um_r;
    big_nxt   = big_r;
    acc_nxt   = acc_r;

    x_sc  = XW'(x_in) <<< GUARD;
    y_sc  = XW'(y_in) <<< GUARD;
    dx    = y_r >>> step_r;
    dy    = x_r >>> step_r;
    tab   = signed'(atan_entry(TAB_IW'(step_r)));
    zr    = z_r + Z_RND;
    t     = zr >>> THETA_SH;
    x_pos = x_r[XW-1] ? '0 : x_r;
    x_ext = EW'($unsigned(x_pos));
    q     = QW'(acc_r >> (GAIN_FRAC + GUARD));

    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          if (x_in == '0 && y_in == '0) begin
            theta_nxt = '0;
            mag_nxt   = '0;
            done_nxt  = 1'b1;
          end else begin
            step_nxt  = '0;
            state_nxt = C_ITER;
            if (x_in < 0) begin
              x_nxt = -x_sc;
              y_nxt = -y_sc;
              z_nxt = (y_in >= 0) ? ANG_PI : -ANG_PI;
            end else begin
              x_nxt = x_sc;
              y_nxt = y_sc;
              z_nxt = '0;
            end
          end
        end
      end
      C_ITER: begin
        if (!y_r[XW-1]) begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + tab;
        end else begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - tab;
        end
        step_nxt = step_r + 1'b1;
        if (step_r == LAST) begin
          state_nxt = C_PREP;
        end
      end
      C_PREP: begin
        if (t > T_HI) begin
          theta_nxt = THETA_W'(T_HI);
        end else if (t < T_LO) begin
          theta_nxt = THETA_W'(T_LO);
        end else begin
          theta_nxt = THETA_W'(t);
        end
        big_nxt   = (x_ext >> MAG_LIM_W) != '0;
        um_nxt    = x_ext[MAG_LIM_W-1:0];
        state_nxt = C_MUL_LO;
      end
      C_MUL_LO: begin
        acc_nxt   = PW'(prod) + P_RND;
        state_nxt = C_MUL_HI;
      end
      C_MUL_HI: begin
        acc_nxt   = acc_r + (PW'(prod) << MUL_SPLIT);
        state_nxt = C_FIN;
      end
      C_FIN: begin
        if (big_r || q > QW'(TRAVEL_MAX)) begin
          mag_nxt = TRAVEL_MAX;
        end else begin
          mag_nxt = q[MAG_W-1:0];
        end
        done_nxt  = 1'b1;
        state_nxt = C_IDLE;
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    step_r  <= step_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    z_r     <= z_nxt;
    theta_r <= theta_nxt;
    mag_r   <= mag_nxt;
    um_r    <= um_nxt;
    big_r   <= big_nxt;
    acc_r   <= acc_nxt;
  end

  assign res.done  = done_r;
  assign res.theta = theta_r;
  assign res.mag   = mag_r;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == C_IDLE)
    else $error("vectoring run requested while the unit is busy");

  a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == C_FIN |=> state_r == C_IDLE && done_r)
    else $error("final step did not report completion");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> theta_r <= 17'sd32768 && theta_r >= -17'sd32768 && mag_r <= TRAVEL_MAX)
    else $error("vectoring result outside its range");
`endif

endmodule

FILE: sv/dual_sensor_drift_calibrator.sv
// Drift calibrator for a pair of optical motion sensors. Each request carries a kind:
// a sample adds its X and Y deltas into the chosen sensor's saturating sums (a sensor
// selector other than one or two is ignored), a start clears the sums, offsets and
// travels and raises the calibrating flag, a stop lowers the flag, and a calibrate
// runs a shared CORDIC in vectoring mode on each sensor's sums in turn. The offset is
// the reference angle (plus or minus a quarter turn, or zero, by the sign of the
// baseline register) minus the measured heading, in units of pi/32768, and the travel
// is the vector length carrying the sign of the baseline. Every request returns one
// result with the flag, both offsets and both travels after the update. Samples, starts
// and stops are handled in the idle state itself, so they stream at one request per
// cycle while the result side keeps up. A calibrate occupies the block while the
// single iterative CORDIC unit runs CORDIC_STEPS rotation steps, one rounding step,
// a gain correction done as two passes through one narrow multiplier, a saturation
// step and a handover step, for each of the two sensors, and then until the result
// register is loaded; a stalled result side lengthens the last part.
// A sensor whose sums are both zero skips the rotation and finishes from idle.
module dual_sensor_drift_calibrator #(
  parameter int CORDIC_STEPS = dsdc_pkg::DSDC_CORDIC_STEPS,
  parameter int SUM_WIDTH    = dsdc_pkg::DSDC_SUM_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  dsdc_in_if.sink                          in_req,
  dsdc_out_if.source                       out_rsp,
  input  logic                             cfg_wr_en,
  input  logic signed [dsdc_pkg::CFG_W-1:0] cfg_wr_data
);
  import dsdc_pkg::*;

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_RUN0 = 2'd1;
  localparam logic [1:0] T_RUN1 = 2'd2;
  localparam logic [1:0] T_OUT  = 2'd3;

  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  logic [1:0]                 state_r, state_nxt;
  logic signed [CFG_W-1:0]    base_r;
  logic                       flag_r, flag_nxt;
  logic signed [SUM_WIDTH-1:0] sum_x_one_r, sum_x_one_nxt, sum_y_one_r, sum_y_one_nxt;
  logic signed [SUM_WIDTH-1:0] sum_x_two_r, sum_x_two_nxt, sum_y_two_r, sum_y_two_nxt;
  logic signed [STORE_W-1:0]  off_one_r, off_one_nxt, off_two_r, off_two_nxt;
  logic signed [TRAVEL_W-1:0] trav_one_r, trav_one_nxt, trav_two_r, trav_two_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic                       out_flag_r;
  logic signed [OFF_W-1:0]    out_off_one_r, out_off_two_r;
  logic signed [TRAVEL_W-1:0] out_trav_one_r, out_trav_two_r;

  logic                        out_free, accept, load_out, cor_start;
  logic signed [SUM_WIDTH-1:0] cor_x, cor_y;
  dsdc_cres_t                  cres;
  logic signed [STORE_W-1:0]   ref_ang, new_off;
  logic signed [TRAVEL_W-1:0]  mag_ext, new_trav;

  // Saturating add of a sample delta into a sum.
  function automatic logic signed [SUM_WIDTH-1:0] sat_add(
    input logic signed [SUM_WIDTH-1:0] a,
    input logic signed [DELTA_W-1:0]   d
  );
    logic signed [SUM_WIDTH:0] s;
    s = (SUM_WIDTH+1)'(a) + (SUM_WIDTH+1)'(d);
    if (s[SUM_WIDTH] != s[SUM_WIDTH-1]) begin
      return s[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
    end
    return s[SUM_WIDTH-1:0];
  endfunction

  // The output register frees up in the same cycle that the sink takes its result,
  // so short requests follow one another without a gap.
  assign out_free     = !out_valid_r || out_rsp.ready;
  assign in_req.ready = (state_r == T_IDLE) && out_free;
  assign accept       = in_req.valid && in_req.ready;

  // The first run takes sensor one straight from the accepted request; the second run
  // is launched from the completion of the first.
  assign cor_x     = (state_r == T_IDLE) ? sum_x_one_r : sum_x_two_r;
  assign cor_y     = (state_r == T_IDLE) ? sum_y_one_r : sum_y_two_r;
  assign cor_start = (accept && in_req.kind == KIND_CAL) ||
                     (state_r == T_RUN0 && cres.done);

  // Only the sign of the baseline matters: it picks the reference angle and the sign
  // given to the travel.
  always_comb begin
    if (base_r > 0) begin
      ref_ang  = STORE_W'(ANG_REF);
    end else if (base_r < 0) begin
      ref_ang  = -STORE_W'(ANG_REF);
    end else begin
      ref_ang  = '0;
    end
    mag_ext = signed'({1'b0, cres.mag});
    new_off = ref_ang - STORE_W'(cres.theta);
    if (base_r > 0) begin
      new_trav = mag_ext;
    end else if (base_r < 0) begin
      new_trav = -mag_ext;
    end else begin
      new_trav = '0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    flag_nxt      = flag_r;
    sum_x_one_nxt = sum_x_one_r;
    sum_y_one_nxt = sum_y_one_r;
    sum_x_two_nxt = sum_x_two_r;
    sum_y_two_nxt = sum_y_two_r;
    off_one_nxt   = off_one_r;
    off_two_nxt   = off_two_r;
    trav_one_nxt  = trav_one_r;
    trav_two_nxt  = trav_two_r;
    load_out      = 1'b0;

    unique case (state_r)
      T_IDLE: begin
        if (accept) begin
          unique case (in_req.kind)
            KIND_SAMPLE: begin
              load_out = 1'b1;
              if (in_req.sensor_id == SENSOR_ONE) begin
                sum_x_one_nxt = sat_add(sum_x_one_r, in_req.delta_x);
                sum_y_one_nxt = sat_add(sum_y_one_r, in_req.delta_y);
              end else if (in_req.sensor_id == SENSOR_TWO) begin
                sum_x_two_nxt = sat_add(sum_x_two_r, in_req.delta_x);
                sum_y_two_nxt = sat_add(sum_y_two_r, in_req.delta_y);
              end
            end
            KIND_START: begin
              load_out      = 1'b1;
              flag_nxt      = 1'b1;
              sum_x_one_nxt = '0;
              sum_y_one_nxt = '0;
              sum_x_two_nxt = '0;
              sum_y_two_nxt = '0;
              off_one_nxt   = '0;
              off_two_nxt   = '0;
              trav_one_nxt  = '0;
              trav_two_nxt  = '0;
            end
            KIND_STOP: begin
              load_out = 1'b1;
              flag_nxt = 1'b0;
            end
            KIND_CAL: begin
              state_nxt = T_RUN0;
            end
            default: state_nxt = T_IDLE;
          endcase
        end
      end
      T_RUN0: begin
        if (cres.done) begin
          off_one_nxt  = new_off;
          trav_one_nxt = new_trav;
          state_nxt    = T_RUN1;
        end
      end
      T_RUN1: begin
        if (cres.done) begin
          off_two_nxt  = new_off;
          trav_two_nxt = new_trav;
          state_nxt    = T_OUT;
        end
      end
      T_OUT: begin
        // The result of a calibrate waits here until the output register is free.
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
      base_r      <= '0;
      flag_r      <= 1'b0;
      sum_x_one_r <= '0;
      sum_y_one_r <= '0;
      sum_x_two_r <= '0;
      sum_y_two_r <= '0;
      off_one_r   <= '0;
      off_two_r   <= '0;
      trav_one_r  <= '0;
      trav_two_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
      flag_r      <= flag_nxt;
      sum_x_one_r <= sum_x_one_nxt;
      sum_y_one_r <= sum_y_one_nxt;
      sum_x_two_r <= sum_x_two_nxt;
      sum_y_two_r <= sum_y_two_nxt;
      off_one_r   <= off_one_nxt;
      off_two_r   <= off_two_nxt;
      trav_one_r  <= trav_one_nxt;
      trav_two_r  <= trav_two_nxt;
    end
  end

  // The result payload is a snapshot of the state as it stands after the request.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_flag_r     <= flag_nxt;
      out_off_one_r  <= OFF_W'(off_one_nxt);
      out_off_two_r  <= OFF_W'(off_two_nxt);
      out_trav_one_r <= trav_one_nxt;
      out_trav_two_r <= trav_two_nxt;
    end
  end

  assign out_rsp.valid            = out_valid_r;
  assign out_rsp.calibrating_flag = out_flag_r;
  assign out_rsp.offset_one       = out_off_one_r;
  assign out_rsp.offset_two       = out_off_two_r;
  assign out_rsp.travel_one       = out_trav_one_r;
  assign out_rsp.travel_two       = out_trav_two_r;

  dsdc_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS),
    .SUM_WIDTH    (SUM_WIDTH)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .x_in  (cor_x),
    .y_in  (cor_y),
    .res   (cres)
  );

`ifndef ASSERT_OFF
  a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_req.kind == KIND_START |=>
      out_rsp.valid && out_rsp.calibrating_flag && out_rsp.travel_one == '0 &&
      out_rsp.offset_two == '0)
    else $error("start request did not return a cleared result");

  a_zero_baseline: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == T_OUT && base_r == '0 |-> trav_one_r == '0 && trav_two_r == '0)
    else $error("travel nonzero with a zero baseline");

  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cres.done |-> state_r == T_RUN0 || state_r == T_RUN1)
    else $error("vectoring result arrived outside a calibrate");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import dsdc_pkg::*;

  // Run limits and the fixed-point constants of the heading estimator.
  localparam int            CYCLE_LIMIT  = 2_000_000;
  localparam int            REPORT_MAX   = 100;
  localparam int            SCALE_BITS   = 8;
  localparam int            HEADING_ROWS = 24;
  localparam longint        PI_ANGLE     = 64'sd2147483648;
  localparam longint        QUARTER_TURN = 16384;
  localparam longint        HALF_TURN    = 32768;
  localparam longint        TRAVEL_CEIL  = 64'sd3037000500;
  localparam longint        GAIN_RECIP   = 636751;

  // Sensor selectors that the block has to ignore.
  localparam logic [ID_W-1:0] SENSOR_SPARE_A = 2'd2;
  localparam logic [ID_W-1:0] SENSOR_SPARE_B = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [ID_W-1:0]           sensor;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
  } req_t;

  typedef struct packed {
    logic                       flag;
    logic signed [OFF_W-1:0]    off_one;
    logic signed [OFF_W-1:0]    off_two;
    logic signed [TRAVEL_W-1:0] trav_one;
    logic signed [TRAVEL_W-1:0] trav_two;
  } result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Locally held copies of everything the testbench drives, so that every input
  // of the block is known from time zero.
  logic                      req_valid  = 1'b0;
  logic [KIND_W-1:0]         req_kind   = KIND_SAMPLE;
  logic [ID_W-1:0]           req_sensor = SENSOR_ONE;
  logic signed [DELTA_W-1:0] req_dx     = '0;
  logic signed [DELTA_W-1:0] req_dy     = '0;
  logic                      rsp_ready  = 1'b0;
  logic                      cfg_wr_en  = 1'b0;
  logic signed [CFG_W-1:0]   cfg_wr_data = '0;

  dsdc_in_if  in_bus();
  dsdc_out_if out_bus();

  assign in_bus.valid     = req_valid;
  assign in_bus.kind      = req_kind;
  assign in_bus.sensor_id = req_sensor;
  assign in_bus.delta_x   = req_dx;
  assign in_bus.delta_y   = req_dy;
  assign out_bus.ready    = rsp_ready;

  dual_sensor_drift_calibrator #(
    .CORDIC_STEPS(DSDC_CORDIC_STEPS),
    .SUM_WIDTH   (DSDC_SUM_WIDTH)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_bus),
    .out_rsp    (out_bus),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Requests waiting to be sent, and results predicted but not yet seen.
  req_t    req_queue[$];
  result_t due_results[$];

  // Shadow of the calibrator's state.
  longint                  sum_x[2];
  longint                  sum_y[2];
  longint                  offset_est[2];
  longint                  travel_est[2];
  logic                    flag_est;
  logic signed [CFG_W-1:0] baseline_now;

  int   mismatches  = 0;
  int   cycle_count = 0;
  logic req_taken   = 1'b0;
  logic fast_mode   = 1'b0;
  int   send_gap    = 0;
  int   send_calm   = 0;
  int   stall_left  = 0;
  int   sink_calm   = 0;

  initial begin
    sum_x[0] = 0; sum_x[1] = 0;
    sum_y[0] = 0; sum_y[1] = 0;
    offset_est[0] = 0; offset_est[1] = 0;
    travel_est[0] = 0; travel_est[1] = 0;
    flag_est = 1'b0;
    baseline_now = '0;
  end

  // Idle length for either side of the handshake: mostly none or short, now and
  // then long, with occasional calm stretches in which nobody idles at all.
  function automatic int gap_len(inout int calm);
    int r;
    if (fast_mode) return 0;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 100);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Arctangent of 2^-i in units of pi/2^31.
  function automatic longint atan_step(int i);
    case (i)
      0:  return 536870912;
      1:  return 316933406;
      2:  return 167458907;
      3:  return 85004756;
      4:  return 42667331;
      5:  return 21354465;
      6:  return 10679838;
      7:  return 5341269;
      8:  return 2670163;
      9:  return 1335087;
      10: return 667544;
      11: return 333772;
      12: return 166886;
      13: return 83443;
      14: return 41722;
      15: return 20861;
      16: return 10430;
      17: return 5215;
      18: return 2608;
      19: return 1304;
      20: return 652;
      21: return 326;
      22: return 163;
      23: return 81;
      default: return 0;
    endcase
  endfunction

  function automatic longint sat_sum(longint acc, longint delta);
    longint hi, lo, r;
    hi = (longint'(1) <<< (DSDC_SUM_WIDTH - 1)) - 1;
    lo = -hi - 1;
    r  = acc + delta;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r;
  endfunction

  // Vectoring CORDIC on one sensor's sums: heading in pi/32768 and vector span.
  function automatic void vector_of(input longint sx, input longint sy,
                                    output longint heading, output longint span);
    longint          x, y, z, dx, dy, t;
    longint unsigned ux, prod;
    int              i;
    heading = 0;
    span    = 0;
    if (sx == 0 && sy == 0) return;
    x = sx <<< SCALE_BITS;
    y = sy <<< SCALE_BITS;
    z = 0;
    // A vector in the left half-plane is turned round first, starting the angle
    // at plus or minus a half turn by the sign of Y.
    if (x < 0) begin
      z = (sy >= 0) ? PI_ANGLE : -PI_ANGLE;
      x = -x;
      y = -y;
    end
    for (i = 0; i < DSDC_CORDIC_STEPS && i < HEADING_ROWS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + atan_step(i);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - atan_step(i);
      end
    end
    t = (z + 32768) >>> 16;
    if (t > HALF_TURN) t = HALF_TURN;
    if (t < -HALF_TURN) t = -HALF_TURN;
    heading = t;
    ux = (x < 0) ? 64'd0 : x;
    if (ux >= (64'd1 << (34 + SCALE_BITS))) begin
      span = TRAVEL_CEIL;
    end else begin
      prod = (ux * GAIN_RECIP + (64'd1 << (19 + SCALE_BITS))) >> (20 + SCALE_BITS);
      span = (prod > TRAVEL_CEIL) ? TRAVEL_CEIL : longint'(prod);
    end
  endfunction

  // Applies one accepted request to the shadow state and returns the result the
  // block should give for it.
  function automatic result_t apply_request(req_t r);
    result_t res;
    longint  heading, span, aim, dir;
    int      k;
    case (r.kind)
      KIND_SAMPLE: begin
        if (r.sensor == SENSOR_ONE || r.sensor == SENSOR_TWO) begin
          k = (r.sensor == SENSOR_ONE) ? 0 : 1;
          sum_x[k] = sat_sum(sum_x[k], longint'(r.dx));
          sum_y[k] = sat_sum(sum_y[k], longint'(r.dy));
        end
      end
      KIND_START: begin
        for (k = 0; k < 2; k++) begin
          sum_x[k] = 0;
          sum_y[k] = 0;
          offset_est[k] = 0;
          travel_est[k] = 0;
        end
        flag_est = 1'b1;
      end
      KIND_STOP: begin
        flag_est = 1'b0;
      end
      default: begin
        // Only the sign of the baseline matters: it picks the reference angle
        // and the sign of the travel.
        if (baseline_now > 0) begin
          aim = QUARTER_TURN;
          dir = 1;
        end else if (baseline_now < 0) begin
          aim = -QUARTER_TURN;
          dir = -1;
        end else begin
          aim = 0;
          dir = 0;
        end
        for (k = 0; k < 2; k++) begin
          vector_of(sum_x[k], sum_y[k], heading, span);
          offset_est[k] = aim - heading;
          travel_est[k] = dir * span;
        end
      end
    endcase
    res.flag     = flag_est;
    res.off_one  = OFF_W'(offset_est[0]);
    res.off_two  = OFF_W'(offset_est[1]);
    res.trav_one = TRAVEL_W'(travel_est[0]);
    res.trav_two = TRAVEL_W'(travel_est[1]);
    return res;
  endfunction

  function automatic void check_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // Request driver: a request stays on the bus until it is accepted, then the
  // next one follows after a random gap.
  always @(negedge clk) begin : drive_requests
    req_t nxt;
    if (!rst_n) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (send_gap > 0) begin
        req_valid <= 1'b0;
        send_gap--;
      end else if (req_queue.size() != 0) begin
        nxt = req_queue.pop_front();
        req_valid  <= 1'b1;
        req_kind   <= nxt.kind;
        req_sensor <= nxt.sensor;
        req_dx     <= nxt.dx;
        req_dy     <= nxt.dy;
        send_gap   = gap_len(send_calm);
      end else begin
        req_valid <= 1'b0;
      end
    end
    req_taken = 1'b0;
  end

  // The result side stalls at random as well.
  always @(negedge clk) begin
    if (!rst_n) begin
      rsp_ready <= 1'b0;
    end else if (stall_left > 0) begin
      rsp_ready <= 1'b0;
      stall_left--;
    end else begin
      rsp_ready <= 1'b1;
      stall_left = gap_len(sink_calm);
    end
  end

  // Monitor: register writes and accepted requests update the shadow state, and
  // every accepted result is held against the oldest prediction.
  always @(posedge clk) begin : watch_bus
    req_t    seen;
    result_t want;
    if (rst_n) begin
      if (cfg_wr_en) baseline_now = cfg_wr_data;
      if (in_bus.valid && in_bus.ready) begin
        req_taken   = 1'b1;
        seen.kind   = in_bus.kind;
        seen.sensor = in_bus.sensor_id;
        seen.dx     = in_bus.delta_x;
        seen.dy     = in_bus.delta_y;
        due_results.push_back(apply_request(seen));
      end
      if (out_bus.valid && out_bus.ready) begin
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) $error("result arrived with no request waiting");
        end else begin
          want = due_results.pop_front();
          check_field("calibrating_flag", want.flag, out_bus.calibrating_flag);
          check_field("offset_one", want.off_one, out_bus.offset_one);
          check_field("offset_two", want.off_two, out_bus.offset_two);
          check_field("travel_one", want.trav_one, out_bus.travel_one);
          check_field("travel_two", want.trav_two, out_bus.travel_two);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic signed [DELTA_W-1:0] rand_delta();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return DELTA_W'($urandom);
    if (r < 8) return DELTA_W'(int'($urandom_range(0, 200)) - 100);
    case ($urandom_range(0, 4))
      0: return 16'sd32767;
      1: return -16'sd32768;
      2: return 16'sd0;
      3: return 16'sd1;
      default: return -16'sd1;
    endcase
  endfunction

  task automatic queue_req(logic [KIND_W-1:0] kind, logic [ID_W-1:0] sensor,
                           logic signed [DELTA_W-1:0] dx, logic signed [DELTA_W-1:0] dy);
    req_t r;
    r.kind   = kind;
    r.sensor = sensor;
    r.dx     = dx;
    r.dy     = dy;
    req_queue.push_back(r);
  endtask

  // A control request carries random payload that the block must ignore.
  task automatic queue_ctrl(logic [KIND_W-1:0] kind);
    queue_req(kind, ID_W'($urandom_range(0, 3)), rand_delta(), rand_delta());
  endtask

  task automatic queue_sample();
    logic [ID_W-1:0] s;
    int              r;
    r = $urandom_range(0, 19);
    if (r < 9) s = SENSOR_ONE;
    else if (r < 18) s = SENSOR_TWO;
    else s = (r == 18) ? SENSOR_SPARE_A : SENSOR_SPARE_B;
    queue_req(KIND_SAMPLE, s, rand_delta(), rand_delta());
  endtask

  // Holds back until every request has gone and every result has come home.
  task automatic wait_drained();
    while (req_queue.size() != 0 || req_valid || due_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_baseline(logic signed [CFG_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly well-formed calibration sessions with random content, the rest noise.
  task automatic run_random(int budget);
    int sent, k, j;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 99) < 80) begin
        queue_ctrl(KIND_START);
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 25);
        for (j = 0; j < k; j++) queue_sample();
        queue_ctrl(KIND_CAL);
        sent += k + 2;
        if ($urandom_range(0, 2) == 0) begin
          k = $urandom_range(1, 10);
          for (j = 0; j < k; j++) queue_sample();
          queue_ctrl(KIND_CAL);
          sent += k + 1;
        end
        if ($urandom_range(0, 9) < 7) begin
          queue_ctrl(KIND_STOP);
          sent++;
        end
      end else begin
        k = $urandom_range(1, 6);
        for (j = 0; j < k; j++)
          queue_req(KIND_W'($urandom_range(0, 3)), ID_W'($urandom_range(0, 3)),
                    rand_delta(), rand_delta());
        sent += k;
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
  endtask

  initial begin : stimulus
    int j;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // With the baseline still at its reset value of zero: a stop while idle,
    // a calibrate on empty sums, and travels that must come out as zero.
    queue_req(KIND_STOP, SENSOR_ONE, 16'sd0, 16'sd0);
    queue_req(KIND_CAL, SENSOR_TWO, 16'sd0, 16'sd0);
    queue_req(KIND_SAMPLE, SENSOR_ONE, 16'sd5, -16'sd7);
    queue_req(KIND_SAMPLE, SENSOR_TWO, -16'sd32768, 16'sd32767);
    queue_req(KIND_CAL, SENSOR_ONE, 16'sd0, 16'sd0);

    write_baseline(16'sd32767);
    queue_req(KIND_START, SENSOR_ONE, 16'sd0, 16'sd0);
    queue_req(KIND_SAMPLE, SENSOR_ONE, 16'sd32767, 16'sd32767);
    queue_req(KIND_SAMPLE, SENSOR_ONE, -16'sd32768, -16'sd32768);
    // Sensor two sits on the negative X axis.
    queue_req(KIND_SAMPLE, SENSOR_TWO, -16'sd5, 16'sd0);
    // Unknown sensors change nothing.
    queue_req(KIND_SAMPLE, SENSOR_SPARE_A, 16'sd100, 16'sd100);
    queue_req(KIND_SAMPLE, SENSOR_SPARE_B, -16'sd100, -16'sd100);
    queue_req(KIND_CAL, SENSOR_ONE, 16'sd0, 16'sd0);
    // A start during calibration restarts it from clean sums.
    queue_req(KIND_START, SENSOR_TWO, 16'sd0, 16'sd0);
    queue_req(KIND_SAMPLE, SENSOR_TWO, 16'sd0, 16'sd1);
    queue_req(KIND_CAL, SENSOR_ONE, 16'sd0, 16'sd0);
    queue_req(KIND_SAMPLE, SENSOR_ONE, -16'sd3, 16'sd4);
    queue_req(KIND_SAMPLE, SENSOR_ONE, 16'sd0, -16'sd32768);
    queue_req(KIND_STOP, SENSOR_ONE, 16'sd0, 16'sd0);
    // Samples and calibrates still act outside a calibration.
    queue_req(KIND_SAMPLE, SENSOR_TWO, 16'sd1, 16'sd1);
    queue_req(KIND_CAL, SENSOR_TWO, 16'sd0, 16'sd0);

    write_baseline(-16'sd32768);
    queue_req(KIND_CAL, SENSOR_ONE, 16'sd0, 16'sd0);

    // A back-to-back run of full-scale samples on both sensors, without idling.
    wait_drained();
    fast_mode = 1'b1;
    queue_req(KIND_START, SENSOR_ONE, 16'sd0, 16'sd0);
    for (j = 0; j < 50; j++) begin
      queue_req(KIND_SAMPLE, SENSOR_ONE, 16'sd32767, -16'sd32768);
      queue_req(KIND_SAMPLE, SENSOR_TWO, -16'sd32768, 16'sd32767);
    end
    queue_req(KIND_CAL, SENSOR_ONE, 16'sd0, 16'sd0);
    queue_req(KIND_SAMPLE, SENSOR_ONE, -16'sd1, 16'sd1);
    queue_req(KIND_SAMPLE, SENSOR_TWO, 16'sd1, -16'sd1);
    queue_req(KIND_CAL, SENSOR_TWO, 16'sd0, 16'sd0);
    queue_req(KIND_STOP, SENSOR_ONE, 16'sd0, 16'sd0);
    wait_drained();
    fast_mode = 1'b0;

    // Random phases, each under its own baseline.
    write_baseline(16'sd1);
    run_random(220);
    write_baseline(-16'sd1);
    run_random(220);
    write_baseline(16'sd0);
    run_random(220);
    write_baseline(16'sd32767);
    run_random(220);
    write_baseline(-16'sd32768);
    run_random(220);
    write_baseline(CFG_W'($urandom));
    run_random(220);
    write_baseline(CFG_W'($urandom));
    run_random(220);

    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
